// ===== sv/fsbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fsbt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PHASE_W       = 18;
  localparam int DUR_W         = 24;
  localparam int VAL_W         = 32;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_START_Z     = 3'd2,
    REG_END_X       = 3'd3,
    REG_END_Y       = 3'd4,
    REG_END_Z       = 3'd5,
    REG_LIFT_HEIGHT = 3'd6
  } cfg_reg_t;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  // Applies a sign to a magnitude and clamps the result to the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat_mag(input logic neg, input logic ovf,
                                               input logic [VAL_W-1:0] mag);
    logic [VAL_W-1:0] r;
    if (ovf) begin
      r = neg ? VAL_MIN : VAL_MAX;
    end else if (!neg) begin
      r = mag[VAL_W-1] ? VAL_MAX : mag;
    end else if (mag > VAL_MIN) begin
      r = VAL_MIN;
    end else begin
      r = VAL_W'(0) - mag;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fsbt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fsbt_cfg_if import fsbt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface fsbt_in_if import fsbt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] swing_phase;
  logic [DUR_W-1:0]          swing_duration;
  modport source (output valid, output swing_phase, output swing_duration, input ready);
  modport sink (input valid, input swing_phase, input swing_duration, output ready);
  modport monitor (input valid, input swing_phase, input swing_duration, input ready);
endinterface

interface fsbt_out_if import fsbt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pos_x;
  logic signed [VAL_W-1:0] pos_y;
  logic signed [VAL_W-1:0] pos_z;
  logic signed [VAL_W-1:0] vel_x;
  logic signed [VAL_W-1:0] vel_y;
  logic signed [VAL_W-1:0] vel_z;
  logic signed [VAL_W-1:0] acc_x;
  logic signed [VAL_W-1:0] acc_y;
  logic signed [VAL_W-1:0] acc_z;
  logic                    param_error;
  modport source (output valid, output pos_x, output pos_y, output pos_z, output vel_x,
                  output vel_y, output vel_z, output acc_x, output acc_y, output acc_z,
                  output param_error, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input vel_x,
                input vel_y, input vel_z, input acc_x, input acc_y, input acc_z,
                input param_error, output ready);
  modport monitor (input valid, input pos_x, input pos_y, input pos_z, input vel_x,
                   input vel_y, input vel_z, input acc_x, input acc_y, input acc_z,
                   input param_error, input ready);
endinterface
`default_nettype wire

// ===== sv/fsbt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fsbt_div import fsbt_pkg::*; #(
  parameter int LANES = 1,
  parameter int NW    = 64,
  parameter int QB    = 32,
  parameter int DW    = DUR_W,
  parameter int SBW   = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [LANES-1:0][NW-1:0]    num,
  input  logic [DW-1:0]               den,
  input  logic [SBW-1:0]              sb,
  output logic [LANES-1:0][QB-1:0]    quo,
  output logic [LANES-1:0]            ovf,
  output logic [DW-1:0]               den_out,
  output logic [SBW-1:0]              sb_out
);

  logic [LANES-1:0][DW-1:0] rem   [QB+1];
  logic [LANES-1:0][QB-1:0] low   [QB+1];
  logic [LANES-1:0]         ov    [QB+1];
  logic [DW-1:0]            dens  [QB+1];
  logic [SBW-1:0]           sbs   [QB+1];
  logic [LANES-1:0][DW:0]   trial [QB+1];
  logic [LANES-1:0]         ge    [QB+1];

  // One quotient bit per stage: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    for (int j = 0; j <= QB; j++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[j][l] = {rem[j][l], low[j][l][QB-1]};
        ge[j][l]    = trial[j][l] >= {1'b0, dens[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens[0] <= den;
      sbs[0]  <= sb;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= DW'(num[l] >> QB);
        low[0][l] <= num[l][QB-1:0];
        ov[0][l]  <= (NW+DW)'(num[l]) >= ((NW+DW)'(den) << QB);
      end
      for (int j = 1; j <= QB; j++) begin
        dens[j] <= dens[j-1];
        sbs[j]  <= sbs[j-1];
        ov[j]   <= ov[j-1];
        for (int l = 0; l < LANES; l++) begin
          rem[j][l] <= ge[j-1][l] ? DW'(trial[j-1][l] - {1'b0, dens[j-1]})
                                  : trial[j-1][l][DW-1:0];
          low[j][l] <= {low[j-1][l][QB-2:0], ge[j-1][l]};
        end
      end
    end
  end

  assign quo     = low[QB];
  assign ovf     = ov[QB];
  assign den_out = dens[QB];
  assign sb_out  = sbs[QB];

endmodule
`default_nettype wire

// ===== sv/foot_swing_bezier_trajectory.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Swing-leg foot trajectory generator.
// Configuration: cfg writes the start point, end point and lift height by register
// index; it is always ready and should only be written while no request is in flight.
// Each request on sample carries a phase and a swing duration and yields exactly one
// result on result: position, velocity and acceleration on three axes plus an error
// flag. x and y follow a smoothstep blend; z lifts to the apex and drops to the end.
// The pipeline depth is set by the two chained bit-serial divisions by the duration:
// one quotient bit per pipeline stage.
// Throughput is one request per clock cycle while result is not stalled.
// The whole pipeline moves on as one; when result is stalled with a valid item at the
// output, sample is held off and every stage keeps its contents, so nothing is lost
// or repeated. Bubbles inside the pipeline are not squeezed out.
// Reset clears all valid bits and the configuration registers to zero.
module foot_swing_bezier_trajectory import fsbt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fsbt_cfg_if.sink    cfg,
  fsbt_in_if.sink     sample,
  fsbt_out_if.source  result
);

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int HALF   = ONE / 2;
  localparam int SW     = FRAC_BITS + 1;
  localparam int SQW    = 2 * SW;
  localparam int DDW    = FRAC_BITS + 4;
  localparam int TW     = FRAC_BITS + 2;
  localparam int BPW    = 2 * FRAC_BITS + 3;
  localparam int DIFF_W = 34;
  localparam int PW     = FRAC_BITS + 38;
  localparam int NW1    = 64;
  localparam int QB1    = 56 - FRAC_BITS;
  localparam int NW2    = 57;
  localparam int QB2    = 32;
  localparam int NS     = QB1 + 42;

  typedef struct packed {
    logic                  err;
    logic [2:0]            aneg;
    logic [2:0]            vneg;
    logic [2:0][VAL_W-1:0] pos;
  } g1_sb_t;

  typedef struct packed {
    logic                  err;
    logic [2:0]            big;
    logic [2:0]            aneg;
    logic [2:0][VAL_W-1:0] vel;
    logic [2:0][VAL_W-1:0] pos;
  } g2_sb_t;

  logic signed [VAL_W-1:0] start_x, start_y, start_z, end_x, end_y, end_z, lift_height;
  logic [NS-1:0] vld;
  logic          adv;

  assign cfg.ready    = 1'b1;
  assign adv          = !vld[NS-1] || result.ready;
  assign sample.ready = adv;
  assign result.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      start_z     <= '0;
      end_x       <= '0;
      end_y       <= '0;
      end_z       <= '0;
      lift_height <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_X:     start_x     <= cfg.data;
        REG_START_Y:     start_y     <= cfg.data;
        REG_START_Z:     start_z     <= cfg.data;
        REG_END_X:       end_x       <= cfg.data;
        REG_END_Y:       end_y       <= cfg.data;
        REG_END_Z:       end_z       <= cfg.data;
        REG_LIFT_HEIGHT: lift_height <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], sample.valid};
    end
  end

  // Input register.
  logic signed [PHASE_W-1:0] ph0;
  logic [DUR_W-1:0]          dur0;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph0  <= sample.swing_phase;
      dur0 <= sample.swing_duration;
    end
  end

  // Clamp the phase and derive the local z phase.
  logic signed [39:0] ph_ext;
  logic [SW-1:0]      s_c;
  logic [SW:0]        s_dbl;
  logic               zl_n;
  logic [SW-1:0]      s1 [2];
  logic               zl1, err1;
  logic [DUR_W-1:0]   dur1;

  assign ph_ext = 40'(ph0);
  assign s_c    = (ph_ext < 0) ? '0 : (ph_ext > 40'(ONE)) ? SW'(ONE) : ph_ext[SW-1:0];
  assign s_dbl  = {s_c, 1'b0};
  assign zl_n   = s_c < SW'(HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1[0] <= s_c;
      s1[1] <= zl_n ? s_dbl[SW-1:0] : SW'(s_dbl - (SW+1)'(ONE));
      zl1   <= zl_n;
      err1  <= (dur0 == '0) || lift_height[VAL_W-1];
      dur1  <= dur0;
    end
  end

  // Square, s*(1-s) and the second derivative of the blend.
  logic [SQW-1:0]        sq_n [2];
  logic [SQW-1:0]        sm_n [2];
  logic signed [DDW-1:0] dd_n [2];
  logic [SW-1:0]         s2_2 [2];
  logic [SW-1:0]         s_2  [2];
  logic [SQW-1:0]        sm2  [2];
  logic signed [DDW-1:0] dd2  [2];
  logic                  zl2, err2;
  logic [DUR_W-1:0]      dur2;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sq_n[p] = SQW'(s1[p]) * SQW'(s1[p]) + SQW'(HALF);
      sm_n[p] = SQW'(s1[p]) * SQW'(SW'(ONE) - s1[p]);
      dd_n[p] = DDW'(6 * ONE) - (DDW'(s1[p]) << 3) - (DDW'(s1[p]) << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 2; p++) begin
        s2_2[p] <= sq_n[p][FRAC_BITS +: SW];
        s_2[p]  <= s1[p];
        sm2[p]  <= sm_n[p];
        dd2[p]  <= dd_n[p];
      end
      zl2  <= zl1;
      err2 <= err1;
      dur2 <= dur1;
    end
  end

  // Blend value and first derivative; axis spans.
  logic [BPW-1:0]           bf_n  [2];
  logic [BPW-1:0]           dbf_n [2];
  logic signed [DIFF_W-1:0] apex, dz_n, p0z_n;
  logic [SW-1:0]            b3    [2];
  logic [SW-1:0]            db3   [2];
  logic signed [DDW-1:0]    dd3   [2];
  logic signed [DIFF_W-1:0] d3    [3];
  logic signed [DIFF_W-1:0] p03   [3];
  logic                     err3;
  logic [DUR_W-1:0]         dur3;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      bf_n[p]  = BPW'(s2_2[p]) * BPW'(TW'(3 * ONE) - (TW'(s_2[p]) << 1)) + BPW'(HALF);
      dbf_n[p] = BPW'(sm2[p]) * BPW'(6) + BPW'(HALF);
    end
  end

  assign apex  = DIFF_W'(start_z) + DIFF_W'(lift_height);
  assign dz_n  = zl2 ? DIFF_W'(lift_height) : DIFF_W'(end_z) - apex;
  assign p0z_n = zl2 ? DIFF_W'(start_z) : apex;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 2; p++) begin
        b3[p]  <= bf_n[p][FRAC_BITS +: SW];
        db3[p] <= dbf_n[p][FRAC_BITS +: SW];
        dd3[p] <= dd2[p];
      end
      d3[0]  <= DIFF_W'(end_x) - DIFF_W'(start_x);
      d3[1]  <= DIFF_W'(end_y) - DIFF_W'(start_y);
      d3[2]  <= dz_n;
      p03[0] <= DIFF_W'(start_x);
      p03[1] <= DIFF_W'(start_y);
      p03[2] <= p0z_n;
      err3   <= err2;
      dur3   <= dur2;
    end
  end

  // Span products.
  logic signed [PW-1:0]     pb4 [3];
  logic signed [PW-1:0]     pv4 [3];
  logic signed [PW-1:0]     pa4 [3];
  logic signed [DIFF_W-1:0] p04 [3];
  logic                     err4;
  logic [DUR_W-1:0]         dur4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        pb4[a] <= PW'(d3[a]) * PW'($signed({1'b0, b3[a / 2]}));
        pv4[a] <= PW'(d3[a]) * PW'($signed({1'b0, db3[a / 2]}));
        pa4[a] <= PW'(d3[a]) * PW'(dd3[a / 2]);
        p04[a] <= p03[a];
      end
      err4 <= err3;
      dur4 <= dur3;
    end
  end

  // Position, and rounded numerators for the divisions by the duration.
  logic [PW-1:0]        pbm [3];
  logic [PW-1:0]        pvm [3];
  logic [PW-1:0]        pam [3];
  logic [PW-1:0]        rnd [3];
  logic signed [PW:0]   rs  [3];
  logic signed [PW:0]   pos_full [3];
  logic [VAL_W-1:0]     pos_n [3];
  logic [NW1-1:0]       nv5 [3];
  logic [NW1-1:0]       na5 [3];
  logic [2:0]           vneg5, aneg5;
  logic [VAL_W-1:0]     pos5 [3];
  logic                 err5;
  logic [DUR_W-1:0]     dur5;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pbm[a] = pb4[a][PW-1] ? PW'(-pb4[a]) : PW'(pb4[a]);
      pvm[a] = pv4[a][PW-1] ? PW'(-pv4[a]) : PW'(pv4[a]);
      pam[a] = pa4[a][PW-1] ? PW'(-pa4[a]) : PW'(pa4[a]);
      rnd[a] = (pbm[a] + PW'(HALF)) >> FRAC_BITS;
      rs[a]  = pb4[a][PW-1] ? -$signed({1'b0, rnd[a]}) : $signed({1'b0, rnd[a]});
      pos_full[a] = (PW+1)'(p04[a]) + rs[a];
      if ((pos_full[a][PW:VAL_W-1] == '0) || (pos_full[a][PW:VAL_W-1] == '1)) begin
        pos_n[a] = pos_full[a][VAL_W-1:0];
      end else begin
        pos_n[a] = pos_full[a][PW] ? VAL_MIN : VAL_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        nv5[a]   <= ((a == 2) ? (NW1'(pvm[a]) << 1) : NW1'(pvm[a])) + NW1'(dur4 >> 1);
        na5[a]   <= ((a == 2) ? (NW1'(pam[a]) << 2) : NW1'(pam[a])) + NW1'(dur4 >> 1);
        vneg5[a] <= pv4[a][PW-1];
        aneg5[a] <= pa4[a][PW-1];
        pos5[a]  <= pos_n[a];
      end
      err5 <= err4;
      dur5 <= dur4;
    end
  end

  // Velocity and first acceleration quotient.
  logic [5:0][NW1-1:0] g1_num;
  logic [5:0][QB1-1:0] g1_q;
  logic [5:0]          g1_ovf;
  logic [DUR_W-1:0]    g1_den;
  g1_sb_t              g1_sb_in, g1_sb_out;

  assign g1_num = {na5[2], na5[1], na5[0], nv5[2], nv5[1], nv5[0]};
  assign g1_sb_in = '{err: err5, aneg: aneg5, vneg: vneg5,
                      pos: {pos5[2], pos5[1], pos5[0]}};

  fsbt_div #(
    .LANES (6),
    .NW    (NW1),
    .QB    (QB1),
    .DW    (DUR_W),
    .SBW   ($bits(g1_sb_t))
  ) u_div1 (
    .clk     (clk),
    .en      (adv),
    .num     (g1_num),
    .den     (dur5),
    .sb      (g1_sb_in),
    .quo     (g1_q),
    .ovf     (g1_ovf),
    .den_out (g1_den),
    .sb_out  (g1_sb_out)
  );

  logic [NW2-1:0]   n26 [3];
  logic [2:0]       big6;
  logic [VAL_W-1:0] vel6 [3];
  g2_sb_t           g2_sb_in, g2_sb_out;
  logic [DUR_W-1:0] dur6;
  logic             err6;
  logic [2:0]       aneg6;
  logic [VAL_W-1:0] pos6 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        vel6[a] <= sat_mag(g1_sb_out.vneg[a],
                           g1_ovf[a] || ((g1_q[a] >> 32) != '0), g1_q[a][VAL_W-1:0]);
        big6[a] <= g1_ovf[a+3];
        n26[a]  <= (NW2'(g1_q[a+3]) << FRAC_BITS) + NW2'(g1_den >> 1);
        pos6[a] <= g1_sb_out.pos[a];
      end
      aneg6 <= g1_sb_out.aneg;
      err6  <= g1_sb_out.err;
      dur6  <= g1_den;
    end
  end

  // Second division for the acceleration.
  logic [2:0][NW2-1:0] g2_num;
  logic [2:0][QB2-1:0] g2_q;
  logic [2:0]          g2_ovf;
  logic [DUR_W-1:0]    g2_den;

  assign g2_num   = {n26[2], n26[1], n26[0]};
  assign g2_sb_in = '{err: err6, big: big6, aneg: aneg6,
                      vel: {vel6[2], vel6[1], vel6[0]},
                      pos: {pos6[2], pos6[1], pos6[0]}};

  fsbt_div #(
    .LANES (3),
    .NW    (NW2),
    .QB    (QB2),
    .DW    (DUR_W),
    .SBW   ($bits(g2_sb_t))
  ) u_div2 (
    .clk     (clk),
    .en      (adv),
    .num     (g2_num),
    .den     (dur6),
    .sb      (g2_sb_in),
    .quo     (g2_q),
    .ovf     (g2_ovf),
    .den_out (g2_den),
    .sb_out  (g2_sb_out)
  );

  logic [VAL_W-1:0] acc_n [3];
  logic             err7;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_n[a] = sat_mag(g2_sb_out.aneg[a], g2_sb_out.big[a] || g2_ovf[a], g2_q[a]);
    end
  end

  // A zero duration never reaches a valid result without the error flag set.
  assign err7 = g2_sb_out.err || (g2_den == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      result.pos_x       <= err7 ? '0 : g2_sb_out.pos[0];
      result.pos_y       <= err7 ? '0 : g2_sb_out.pos[1];
      result.pos_z       <= err7 ? '0 : g2_sb_out.pos[2];
      result.vel_x       <= err7 ? '0 : g2_sb_out.vel[0];
      result.vel_y       <= err7 ? '0 : g2_sb_out.vel[1];
      result.vel_z       <= err7 ? '0 : g2_sb_out.vel[2];
      result.acc_x       <= err7 ? '0 : acc_n[0];
      result.acc_y       <= err7 ? '0 : acc_n[1];
      result.acc_z       <= err7 ? '0 : acc_n[2];
      result.param_error <= err7;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fsbt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fsbt_checker (
  input logic          clk,
  input logic          rst,
  fsbt_in_if.sink      sample,
  fsbt_out_if.source   result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.pos_x)
      && $stable(result.acc_z) && $stable(result.param_error))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.param_error |-> result.pos_x == 0 && result.vel_y == 0
      && result.acc_z == 0)
    else $error("error result carries non-zero values");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result.valid || result.ready |-> sample.ready)
    else $error("request refused while the output can move");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !sample.ready)
    else $error("request taken while the output is stalled");

endmodule

bind foot_swing_bezier_trajectory fsbt_checker u_fsbt_checker (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .result (result)
);
`default_nettype wire
